[sv/mrr_pkg.sv]
// Package for the masked row reduce block: widths, mode codes and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
package mrr_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = SAMPLE_W + 10;
  localparam int CNT_W     = 11;
  localparam int OUT_W     = 32;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_SUM  = 2'd0,
    MODE_MEAN = 2'd1,
    MODE_MIN  = 2'd2,
    MODE_MAX  = 2'd3
  } mode_e;

  // controller -> datapath
  typedef struct packed {
    logic accum;        // fold the current sample into the row state
    logic load_direct;  // write sum/min/max/empty result, clear row state
    logic div_start;    // load divider from row state, clear row state
    logic div_step;     // one quotient bit
    logic load_div;     // write mean result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic row_empty;
    logic mode_mean;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

[sv/mrr_chan_if.sv]
// Channel interfaces of the masked row reduce block: sample input, result
// output and mode write port. Depends on mrr_pkg.
interface mrr_smp_if;
  logic                              valid;
  logic                              ready;
  logic signed [mrr_pkg::SAMPLE_W-1:0] sample;
  logic                              sample_valid;
  logic                              row_last;

  modport source (output valid, sample, sample_valid, row_last, input ready);
  modport sink   (input valid, sample, sample_valid, row_last, output ready);
endinterface

interface mrr_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [mrr_pkg::OUT_W-1:0]  reduced_value;
  logic                              row_empty;

  modport source (output valid, reduced_value, row_empty, input ready);
  modport sink   (input valid, reduced_value, row_empty, output ready);
endinterface

interface mrr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reduce_mode;

  modport source (output valid, reduce_mode, input ready);
  modport sink   (input valid, reduce_mode, output ready);
endinterface

[sv/mrr_ctrl.sv]
// Controller of the masked row reduce block: sequences sample intake,
// row close, the mean divider and result hand-off. Depends on mrr_pkg.
module mrr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  mrr_pkg::sts_t sts_i,
  output mrr_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_ACCUM  = 4'b0001,
    ST_FINISH = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o  = 1'b1;
        cmd_o.accum = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.mode_mean && !sts_i.row_empty) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (sts_i.out_free) begin
          cmd_o.load_direct = 1'b1;
          state_d           = ST_ACCUM;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_div = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_direct || cmd_o.load_div) |-> sts_i.out_free)
    else $error("result written while previous one pending");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> (state_q == ST_DIV || state_q == ST_DONE))
    else $error("divider left early");

endmodule

[sv/mrr_dpath.sv]
// Datapath of the masked row reduce block: row state, mode register,
// bit-serial mean divider and output register. Depends on mrr_pkg.
module mrr_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mrr_pkg::cmd_t                        cmd_i,
  output mrr_pkg::sts_t                        sts_o,
  input  logic signed [mrr_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 sample_valid_i,
  input  logic                                 cfg_valid_i,
  input  logic [1:0]                           cfg_mode_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mrr_pkg::OUT_W-1:0]     out_value_o,
  output logic                                 out_empty_o
);

  localparam int SW = mrr_pkg::SUM_W;
  localparam int PW = mrr_pkg::SAMPLE_W;
  localparam int OW = mrr_pkg::OUT_W;
  localparam int CW = mrr_pkg::CNT_W;

  localparam logic signed [PW-1:0] SMP_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] SMP_MIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW:0]   OUT_HI  = {{(SW+2-OW){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [SW:0]   OUT_LO  = {{(SW+2-OW){1'b1}}, {(OW-1){1'b0}}};

  function automatic logic signed [OW-1:0] clamp_out(input logic signed [SW:0] v);
    logic signed [OW-1:0] r;
    if (v > OUT_HI) begin
      r = OUT_HI[OW-1:0];
    end else if (v < OUT_LO) begin
      r = OUT_LO[OW-1:0];
    end else begin
      r = v[OW-1:0];
    end
    return r;
  endfunction

  mrr_pkg::mode_e mode_q;

  logic signed [SW-1:0] sum_q, sum_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [PW-1:0] min_q, min_d, max_q, max_d;

  logic [SW-1:0]                  dvd_q, dvd_d;
  logic [CW:0]                    rem_q, rem_d;
  logic [CW-1:0]                  dsr_q;
  logic                           neg_q;
  logic [mrr_pkg::DIV_CNT_W-1:0]  step_q;

  logic                  out_valid_q;
  logic signed [OW-1:0]  out_value_q;
  logic                  out_empty_q;

  logic signed [SW:0] sum_wide;
  logic signed [SW:0] quo_signed;
  logic [SW-1:0]      sum_mag;
  logic [CW:0]        trial;
  logic               take;
  logic               clear_row;
  logic signed [OW-1:0] direct_val;

  // Mode register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mrr_pkg::MODE_SUM;
    end else if (cfg_valid_i) begin
      mode_q <= mrr_pkg::mode_e'(cfg_mode_i);
    end
  end

  // Row state update with saturating sum and count
  assign sum_wide = {sum_q[SW-1], sum_q} + {{(SW+1-PW){sample_i[PW-1]}}, sample_i};
  assign clear_row = cmd_i.load_direct || cmd_i.div_start;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    min_d = min_q;
    max_d = max_q;
    if (clear_row) begin
      sum_d = '0;
      cnt_d = '0;
      min_d = SMP_MAX;
      max_d = SMP_MIN;
    end else if (cmd_i.accum && sample_valid_i) begin
      if (sum_wide[SW] != sum_wide[SW-1]) begin
        sum_d = sum_wide[SW] ? SUM_MIN : SUM_MAX;
      end else begin
        sum_d = sum_wide[SW-1:0];
      end
      if (cnt_q != mrr_pkg::CNT_MAX) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (sample_i < min_q) begin
        min_d = sample_i;
      end
      if (sample_i > max_q) begin
        max_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      min_q <= SMP_MAX;
      max_q <= SMP_MIN;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle
  assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign trial   = {rem_q[CW-1:0], dvd_q[SW-1]};
  assign take    = trial >= {1'b0, dsr_q};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (cmd_i.div_start) begin
      dvd_d = sum_mag;
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      dvd_d = {dvd_q[SW-2:0], take};
      rem_d = take ? (trial - {1'b0, dsr_q}) : trial;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (cmd_i.div_start) begin
      dsr_q <= cnt_q;
      neg_q <= sum_q[SW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_start) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end
  end

  assign quo_signed = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

  // Result select for everything but the mean
  always_comb begin
    case (mode_q)
      mrr_pkg::MODE_MIN: direct_val = min_q;
      mrr_pkg::MODE_MAX: direct_val = max_q;
      default:           direct_val = clamp_out({sum_q[SW-1], sum_q});
    endcase
    if (cnt_q == '0) begin
      direct_val = '0;
    end
  end

  // Output register: hold until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_direct || cmd_i.load_div) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_direct) begin
      out_value_q <= direct_val;
      out_empty_q <= (cnt_q == '0);
    end else if (cmd_i.load_div) begin
      out_value_q <= clamp_out(quo_signed);
      out_empty_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_empty_o = out_empty_q;

  assign sts_o.row_empty = (cnt_q == '0);
  assign sts_o.mode_mean = (mode_q == mrr_pkg::MODE_MEAN);
  assign sts_o.div_last  = (step_q == mrr_pkg::DIV_CNT_W'(mrr_pkg::DIV_STEPS - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("row minimum above maximum");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (sum_q == '0 && min_q == SMP_MAX && max_q == SMP_MIN))
    else $error("row state not clear with zero count");

endmodule

[sv/masked_row_reduce_core.sv]
// Top level of the masked row reduce block: masked sum, mean, min or
// max of a row of Q16.16 samples. Depends on mrr_pkg, the channel
// interfaces, mrr_ctrl and mrr_dpath.
//
// Usage:
//   smp_i  - sample channel; one transfer per row element, row_last marks the
//            final one. Elements with sample_valid low are skipped.
//   res_o  - one result transfer per row: reduced_value, or row_empty set with
//            a zero value when the row held no valid sample.
//   cfg_i  - mode write (0 sum, 1 mean, 2 min, 3 max); always ready, write it
//            only while no row is open or result outstanding.
// Throughput: one sample per cycle inside a row. After the row_last transfer
// the sample channel stays not ready through the close state (sum/min/max)
// or, for mean, through the close state, the divider steps (one quotient bit
// per cycle over the 42-bit sum) and the write state; each result write waits
// for the output register to be free. The result leaves through the output
// register, which the close or write state loads.
// A stalled receiver holds the result in the output register; samples of the
// next row keep flowing, and only its result write waits for the register to free.
// Reset clears the mode to sum, empties the row state and drops any result.
module masked_row_reduce_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrr_smp_if.sink   smp_i,
  mrr_res_if.source res_o,
  mrr_cfg_if.sink   cfg_i
);

  mrr_pkg::cmd_t cmd;
  mrr_pkg::sts_t sts;

  // Mode register takes every write at once
  assign cfg_i.ready = 1'b1;

  mrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .in_last_i  (smp_i.row_last),
    .in_ready_o (smp_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mrr_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (smp_i.sample),
    .sample_valid_i (smp_i.sample_valid),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_mode_i     (cfg_i.reduce_mode),
    .out_valid_o    (res_o.valid),
    .out_ready_i    (res_o.ready),
    .out_value_o    (res_o.reduced_value),
    .out_empty_o    (res_o.row_empty)
  );

endmodule
